// ===== rtl/captive_dns_answer_builder_macros.svh =====
// Assertion macros for the top-level file that checks this block.
`ifndef CAPTIVE_DNS_ANSWER_BUILDER_MACROS_SVH
`define CAPTIVE_DNS_ANSWER_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDAB_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdab assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CDAB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdab assertion failed");

`endif

// ===== rtl/cdab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdab_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LBL_W = 16;
	localparam int HDR_BYTES = 12;
	localparam int QTAIL_BYTES = 5;
	localparam logic [LBL_W-1:0] UNREACHED = 16'hFFFF;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LABELS = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [1:0] JOB_NONE = 2'd0;
	localparam logic [1:0] JOB_BYTE = 2'd1;
	localparam logic [1:0] JOB_ANSWER = 2'd2;
	localparam logic [1:0] JOB_ABORT = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TTL = 2'd1;

	localparam logic [7:0] FLAGS_HI = 8'h81;
	localparam logic [7:0] FLAGS_LO = 8'h80;
	localparam logic [7:0] NAME_PTR_HI = 8'hC0;
	localparam logic [7:0] NAME_PTR_LO = 8'h0C;
	localparam logic [7:0] RR_LEN = 8'h04;

	localparam int ANSWER_BYTES = 16;
	localparam int CNT_W = $clog2(ANSWER_BYTES + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic       emit;
		logic [7:0] data;
	} job_t;

	function automatic logic [7:0] answer_byte(input logic [3:0] idx,
			input logic [31:0] ttl, input logic [31:0] addr);
		logic [7:0] r;
		case (idx)
			4'd0: r = NAME_PTR_HI;
			4'd1: r = NAME_PTR_LO;
			4'd2: r = 8'h00;
			4'd3: r = 8'h01;
			4'd4: r = 8'h00;
			4'd5: r = 8'h01;
			4'd6: r = ttl[31:24];
			4'd7: r = ttl[23:16];
			4'd8: r = ttl[15:8];
			4'd9: r = ttl[7:0];
			4'd10: r = 8'h00;
			4'd11: r = RR_LEN;
			4'd12: r = addr[31:24];
			4'd13: r = addr[23:16];
			4'd14: r = addr[15:8];
			default: r = addr[7:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cdab_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdab_parser import cdab_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       query_valid,
	output logic            query_ready,
	input  wire logic [7:0] query_byte,
	input  wire logic       query_end,
	output job_t            job_s1,
	output logic            job_valid_s1,
	input  wire logic       job_take
);

	localparam logic [16:0] MAX_W = 17'(MAX_FRAME_BYTES);

	logic [POS_W-1:0] byte_pos_q;
	logic [LBL_W-1:0] next_label_q;
	logic [POS_W-1:0] qend_q;
	logic [1:0]       phase_q;

	logic [POS_W-1:0] n_pos;
	logic [LBL_W-1:0] n_label;
	logic [POS_W-1:0] n_qend;
	logic [1:0]       n_phase;
	logic             emit;
	logic [7:0]       ob;
	logic             over;
	logic [16:0]      p17;
	logic [16:0]      nx17;
	job_t             job;
	logic             accept;

	assign query_ready = !job_valid_s1 || job_take;
	assign accept = query_valid && query_ready;

	always_comb begin
		p17 = 17'(byte_pos_q);
		nx17 = p17 + 17'(query_byte) + 17'd1;
		over = p17 >= MAX_W;
		n_pos = byte_pos_q;
		n_label = next_label_q;
		n_qend = qend_q;
		n_phase = phase_q;
		emit = 1'b0;
		ob = query_byte;
		if (!over) begin
			unique case (phase_q)
				PH_HEADER: begin
					emit = 1'b1;
					if (p17 == 17'd2) ob = FLAGS_HI;
					else if (p17 == 17'd3) ob = FLAGS_LO;
					else if (p17 == 17'd6) ob = 8'h00;
					else if (p17 == 17'd7) ob = 8'h01;
					if (p17 + 17'd1 >= 17'(HDR_BYTES)) n_phase = PH_LABELS;
				end
				PH_LABELS: begin
					emit = 1'b1;
					if (p17 == 17'(next_label_q)) begin
						if (query_byte == 8'h00) begin
							if (p17 + 17'(QTAIL_BYTES) <= MAX_W) begin
								n_qend = POS_W'(p17 + 17'(QTAIL_BYTES));
								n_phase = PH_TAIL;
							end else begin
								n_label = UNREACHED;
							end
						end else begin
							n_label = (nx17 >= 17'(UNREACHED)) ? UNREACHED : LBL_W'(nx17);
						end
					end
				end
				PH_TAIL: begin
					emit = 1'b1;
					if (p17 + 17'd1 >= 17'(qend_q)) n_phase = PH_DONE;
				end
				PH_DONE: begin
				end
			endcase
			n_pos = POS_W'(p17 + 17'd1);
		end

		job.emit = emit;
		job.data = ob;
		if (!query_end) begin
			job.kind = emit ? JOB_BYTE : JOB_NONE;
		end else if (over || n_phase != PH_DONE) begin
			job.kind = JOB_ABORT;
		end else begin
			job.kind = JOB_ANSWER;
		end

		if (query_end) begin
			n_pos = '0;
			n_label = LBL_W'(HDR_BYTES);
			n_qend = '0;
			n_phase = PH_HEADER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			next_label_q <= LBL_W'(HDR_BYTES);
			qend_q <= '0;
			phase_q <= PH_HEADER;
			job_valid_s1 <= 1'b0;
		end else if (accept) begin
			byte_pos_q <= n_pos;
			next_label_q <= n_label;
			qend_q <= n_qend;
			phase_q <= n_phase;
			job_valid_s1 <= 1'b1;
		end else if (job_take) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cdab_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdab_emitter import cdab_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire job_t        job_in,
	input  wire logic        job_valid,
	output logic             job_take,
	input  wire logic [31:0] answer_address,
	input  wire logic [31:0] answer_ttl,
	output logic             reply_valid,
	input  wire logic        reply_ready,
	output logic [7:0]       reply_byte,
	output logic             reply_end,
	output logic             reply_abort
);

	logic             job_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       data_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_item;
	logic [3:0]       ans_idx;

	assign last_item = (kind_q != JOB_ANSWER) || (cnt_q == CNT_W'(ANSWER_BYTES));
	assign job_take = !job_valid_q || (reply_ready && last_item);
	assign reply_valid = job_valid_q;
	assign ans_idx = 4'(cnt_q - CNT_W'(1));

	always_comb begin
		reply_abort = kind_q == JOB_ABORT;
		reply_end = reply_abort || (kind_q == JOB_ANSWER && cnt_q == CNT_W'(ANSWER_BYTES));
		if (reply_abort) begin
			reply_byte = 8'h00;
		end else if (kind_q == JOB_ANSWER && cnt_q != '0) begin
			reply_byte = answer_byte(ans_idx, answer_ttl, answer_address);
		end else begin
			reply_byte = data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			kind_q <= JOB_NONE;
			cnt_q <= '0;
		end else if (job_take && job_valid) begin
			job_valid_q <= job_in.kind != JOB_NONE;
			kind_q <= job_in.kind;
			cnt_q <= (job_in.kind == JOB_ANSWER && !job_in.emit) ? CNT_W'(1) : '0;
		end else if (job_take) begin
			job_valid_q <= 1'b0;
		end else if (reply_valid && reply_ready) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_take && job_valid) begin
			data_q <= job_in.data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/captive_dns_answer_builder.sv =====
// Path: an accepted query byte passes the parser's job register and then the emitter's output register.
// Throughput: one query byte per cycle while the reply output accepts; the final byte of a good frame stalls the input
// while the answer record leaves the single output register.
// An aborted frame yields one request on its final byte.
// Reset: arst_n clears the parser to the header phase, empties both stages and restores
// the address to 192.168.4.1 and the TTL to 60 seconds.
`timescale 1ns / 1ps
`default_nettype none
`include "captive_dns_answer_builder_macros.svh"

module captive_dns_answer_builder import cdab_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 query_valid,
	output logic                      query_ready,
	input  wire logic [7:0]           query_byte,
	input  wire logic                 query_end,
	output logic                      reply_valid,
	input  wire logic                 reply_ready,
	output logic [7:0]                reply_byte,
	output logic                      reply_end,
	output logic                      reply_abort,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	logic [31:0] answer_address_q;
	logic [31:0] answer_ttl_q;
	job_t        job_s1;
	logic        job_valid_s1;
	logic        job_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_address_q <= 32'hC0A8_0401;
			answer_ttl_q <= 32'd60;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ANSWER_ADDRESS: answer_address_q <= cfg_data;
				REG_ANSWER_TTL: answer_ttl_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cdab_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query_byte   (query_byte),
		.query_end    (query_end),
		.job_s1       (job_s1),
		.job_valid_s1 (job_valid_s1),
		.job_take     (job_take)
	);

	cdab_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_in         (job_s1),
		.job_valid      (job_valid_s1),
		.job_take       (job_take),
		.answer_address (answer_address_q),
		.answer_ttl     (answer_ttl_q),
		.reply_valid    (reply_valid),
		.reply_ready    (reply_ready),
		.reply_byte     (reply_byte),
		.reply_end      (reply_end),
		.reply_abort    (reply_abort)
	);

	`CDAB_ASSERT_SAME(a_abort_ends_frame, reply_valid && reply_abort, reply_end && reply_byte == 8'h00)
	`CDAB_ASSERT_NEXT(a_job_held, job_valid_s1 && !job_take, job_valid_s1 && $stable(job_s1))
	`CDAB_ASSERT_SAME(a_input_waits, query_valid && query_ready, !job_valid_s1 || job_take)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cdab_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       fin;
		logic       abort;
	} reply_t;

	class reply_scoreboard;
		logic [31:0] address;
		logic [31:0] ttl;
		logic [15:0] pos;
		logic [15:0] next_label;
		logic [15:0] question_end;
		logic [1:0]  phase;
		reply_t      due[$];
		int          mismatches;
		int          checked;
		int          answered;
		int          aborted;

		function new();
			address = 32'hC0A80401;
			ttl = 32'd60;
			mismatches = 0;
			checked = 0;
			answered = 0;
			aborted = 0;
			restart();
		endfunction

		function void restart();
			pos = 16'd0;
			next_label = 16'(HDR_BYTES);
			question_end = 16'd0;
			phase = PH_HEADER;
		endfunction

		function void push(logic [7:0] data, logic fin, logic abort);
			reply_t r;
			r.data = data;
			r.fin = fin;
			r.abort = abort;
			due.push_back(r);
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Works out the reply bytes that one accepted query byte causes.
		function int note_query(logic [7:0] b, logic fin);
			int p;
			int nx;
			bit over;
			bit emit;
			logic [7:0] ob;
			logic [127:0] rec;
			int n;
			p = pos;
			over = (p >= MAX_FRAME_BYTES);
			emit = 1'b0;
			ob = b;
			n = 0;
			if (!over) begin
				case (phase)
					PH_HEADER: begin
						emit = 1'b1;
						case (p)
							2: ob = FLAGS_HI;
							3: ob = FLAGS_LO;
							6: ob = 8'h00;
							7: ob = 8'h01;
							default: ;
						endcase
						if (p + 1 >= HDR_BYTES)
							phase = PH_LABELS;
					end
					PH_LABELS: begin
						emit = 1'b1;
						if (p == int'(next_label)) begin
							if (b == 8'h00) begin
								if (p + QTAIL_BYTES <= MAX_FRAME_BYTES) begin
									question_end = 16'(p + QTAIL_BYTES);
									phase = PH_TAIL;
								end else begin
									next_label = UNREACHED;
								end
							end else begin
								nx = p + int'(b) + 1;
								next_label = (nx >= int'(UNREACHED)) ? UNREACHED : 16'(nx);
							end
						end
					end
					PH_TAIL: begin
						emit = 1'b1;
						if (p + 1 >= int'(question_end))
							phase = PH_DONE;
					end
					default: ;
				endcase
				pos = 16'(p + 1);
			end
			if (!fin) begin
				if (emit) begin
					push(ob, 1'b0, 1'b0);
					n = 1;
				end
				return n;
			end
			if (over || phase != PH_DONE) begin
				push(8'h00, 1'b1, 1'b1);
				aborted++;
				restart();
				return 1;
			end
			if (emit) begin
				push(ob, 1'b0, 1'b0);
				n++;
			end
			rec = {NAME_PTR_HI, NAME_PTR_LO, 8'h00, 8'h01, 8'h00, 8'h01, ttl,
				8'h00, RR_LEN, address};
			for (int i = 0; i < ANSWER_BYTES; i++)
				push(rec[127 - 8 * i -: 8], i == ANSWER_BYTES - 1, 1'b0);
			n += ANSWER_BYTES;
			answered++;
			restart();
			return n;
		endfunction

		task report(string msg);
			if (mismatches < 40)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_reply(logic [7:0] data, logic fin, logic abort);
			reply_t want;
			checked++;
			if (due.size() == 0) begin
				report($sformatf("reply %0d with nothing due: byte %02h end %b abort %b",
					checked, data, fin, abort));
				return;
			end
			want = due.pop_front();
			if (data !== want.data || fin !== want.fin || abort !== want.abort)
				report($sformatf("reply %0d: byte %02h end %b abort %b, wanted %02h %b %b",
					checked, data, fin, abort, want.data, want.fin, want.abort));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 query_valid = 1'b0;
	wire logic            query_ready;
	logic [7:0]           query_byte = 8'h00;
	logic                 query_end = 1'b0;
	wire logic            reply_valid;
	logic                 reply_ready = 1'b0;
	wire logic [7:0]      reply_byte;
	wire logic            reply_end;
	wire logic            reply_abort;
	logic                 cfg_valid = 1'b0;
	wire logic            cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ANSWER_ADDRESS;
	logic [31:0]          cfg_data = 32'd0;

	bit                   calm = 1'b0;
	int                   sent_items = 0;
	logic [7:0]           frame_bytes[$];
	reply_scoreboard      sb = new();

	captive_dns_answer_builder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.query_valid(query_valid),
		.query_ready(query_ready),
		.query_byte (query_byte),
		.query_end  (query_end),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply_byte (reply_byte),
		.reply_end  (reply_end),
		.reply_abort(reply_abort),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("FAILED: results differ");
		$finish;
	end

	always @(negedge clk) begin
		reply_ready <= calm || ($urandom_range(0, 99) >= 21);
	end

	always @(posedge clk) begin
		if (arst_n && reply_valid && reply_ready)
			sb.check_reply(reply_byte, reply_end, reply_abort);
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_header();
		repeat (HDR_BYTES) frame_bytes.push_back(rand_byte());
	endfunction

	function automatic void add_labels(int count);
		int len;
		repeat (count) begin
			len = $urandom_range(1, 20);
			frame_bytes.push_back(8'(len));
			repeat (len) frame_bytes.push_back(rand_byte());
		end
	endfunction

	function automatic void random_frame();
		int kind;
		int cut;
		frame_bytes.delete();
		kind = $urandom_range(0, 99);
		add_header();
		if (kind < 93)
			add_labels($urandom_range(0, 4));
		if (kind < 85) begin
			frame_bytes.push_back(8'h00);
			repeat (4) frame_bytes.push_back(rand_byte());
			repeat ($urandom_range(0, 5)) frame_bytes.push_back(rand_byte());
			if (kind >= 70) begin
				cut = $urandom_range(1, frame_bytes.size() - 1);
				frame_bytes = frame_bytes[0:cut-1];
			end
		end else if (kind < 93) begin
			frame_bytes.push_back(8'd30);
			repeat ($urandom_range(0, 29)) frame_bytes.push_back(rand_byte());
		end else begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 40)) frame_bytes.push_back(rand_byte());
		end
	endfunction

	task automatic send_query(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 21) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query_valid <= 1'b1;
		query_byte <= b;
		query_end <= fin;
		do @(posedge clk); while (!query_ready);
		void'(sb.note_query(b, fin));
		sent_items++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_query(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic hold_query();
		@(negedge clk);
		query_valid <= 1'b0;
	endtask

	task automatic drain();
		hold_query();
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_answer(input logic [31:0] addr, input logic [31:0] secs);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ANSWER_ADDRESS;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		sb.address = addr;
		@(negedge clk);
		cfg_index <= REG_ANSWER_TTL;
		cfg_data <= secs;
		do @(posedge clk); while (!cfg_ready);
		sb.ttl = secs;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] addr_set[5];
		logic [31:0] ttl_set[5];
		int quota;
		int frames;
		frames = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The shortest good query, with every header bit set and an empty name.
		frame_bytes.delete();
		repeat (HDR_BYTES) frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		repeat (4) frame_bytes.push_back(8'hFF);
		send_frame();
		frame_bytes = '{8'h00};
		send_frame();
		frame_bytes.delete();
		repeat (HDR_BYTES) frame_bytes.push_back(8'h00);
		send_frame();

		addr_set = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
		ttl_set = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom_range(0, 86400), $urandom};
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			set_answer(addr_set[ph], ttl_set[ph]);
			quota = 70 * (ph + 1);
			while (sent_items < quota) begin
				calm = (frames >= 2 && frames < 5);
				random_frame();
				send_frame();
				frames++;
			end
		end
		calm = 1'b0;
		drain();

		$display("Ran %0d query frames: %0d answered, %0d aborted, %0d reply requests checked.",
			sb.answered + sb.aborted, sb.answered, sb.aborted, sb.checked);
		$display("Address and TTL went through reset, all-zero, all-one and random values.");
		if (sb.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cdab_pkg.sv
rtl/cdab_parser.sv
rtl/cdab_emitter.sv
rtl/captive_dns_answer_builder.sv
tb/sv/testbench.sv
